// File: sv/fpcp_pkg.sv
// Shared types, constants and the CRC-16/CCITT-FALSE byte update for the
// framed packet parser. No dependencies.
package fpcp_pkg;

	// Default largest payload a frame may carry
	localparam int MAX_PAYLOAD_DEF = 32;

	// Register reset and CRC constants
	localparam logic [7:0]  FRAME_START_RST = 8'hA5;
	localparam logic [15:0] CRC_INIT        = 16'hFFFF;
	localparam logic [15:0] CRC_POLY        = 16'h1021;

	// Controller states, one-hot
	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_CMD    = 8'b0000_0010,
		ST_LEN    = 8'b0000_0100,
		ST_DATA   = 8'b0000_1000,
		ST_CRC_LO = 8'b0001_0000,
		ST_CRC_HI = 8'b0010_0000,
		ST_RD     = 8'b0100_0000,
		ST_LOAD   = 8'b1000_0000
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic start;       // start byte seen, restart the CRC
		logic take_cmd;
		logic take_len;
		logic take_data;
		logic take_crc_lo;
		logic take_crc_hi;
		logic rd_issue;    // read payload store at the drain index
		logic out_load;    // load the output register
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic start_hit;   // incoming byte equals frame_start
		logic len_big;     // incoming byte exceeds the payload limit
		logic len_zero;
		logic data_done;   // this data beat is the final payload byte
		logic crc_ok;      // incoming high byte completes a matching CRC
		logic rd_last;     // drain index is at the final result
		logic out_free;    // output register can take a result this cycle
	} sts_t;

	// CRC-16/CCITT-FALSE update over one byte, MSB first
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// File: sv/framed_packet_crc_parser_core.sv
// Framed packet parser with CRC-16/CCITT-FALSE check: top level joining the
// controller and datapath. Depends on fpcp_pkg, fpcp_ctrl, fpcp_dpath.
//
// Received bytes are taken one per cycle (in_valid/in_ready) while a frame is
// being hunted or received: start byte (frame_start), command, length,
// payload, then the CRC low byte and high byte. On the CRC high byte of a good
// frame the block drains its payload from the internal store, one result beat
// per payload byte (one beat for an empty frame), last set on the final beat.
// Each result takes one store read (ST_RD) and then one output load (ST_LOAD),
// which waits while the output register is held, and in_ready stays low for
// the whole drain. The last beat may wait in the output register while the
// next frame is already taken.
// Bad-CRC and over-length frames are dropped with no output.
module framed_packet_crc_parser_core #(
	parameter int MAX_PAYLOAD = fpcp_pkg::MAX_PAYLOAD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  command,
	output logic [5:0]  payload_length,
	output logic [7:0]  payload_byte,
	output logic [4:0]  byte_index,
	output logic [15:0] received_crc,
	output logic        last
);

	fpcp_pkg::cmd_t cmd;
	fpcp_pkg::sts_t sts;

	// Frame sequencing
	fpcp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Storage, CRC and output register
	fpcp_dpath #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.rx_byte        (rx_byte),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.command        (command),
		.payload_length (payload_length),
		.payload_byte   (payload_byte),
		.byte_index     (byte_index),
		.received_crc   (received_crc),
		.last           (last)
	);

endmodule

// File: sv/fpcp_dpath.sv
// Datapath of the framed packet parser: frame_start register, CRC, payload
// store, drain counters and the output register. Depends on fpcp_pkg.
module fpcp_dpath #(
	parameter int MAX_PAYLOAD = fpcp_pkg::MAX_PAYLOAD_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata,
	input  logic [7:0]        rx_byte,
	input  fpcp_pkg::cmd_t    cmd,
	output fpcp_pkg::sts_t    sts,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        command,
	output logic [5:0]        payload_length,
	output logic [7:0]        payload_byte,
	output logic [4:0]        byte_index,
	output logic [15:0]       received_crc,
	output logic              last
);

	localparam int LW = $clog2(MAX_PAYLOAD + 1);
	localparam int IW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam logic [7:0] MaxByte = 8'(MAX_PAYLOAD);

	logic [7:0]    frame_start_q;
	logic [15:0]   crc_q;
	logic [7:0]    cmd_byte_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] fill_q;
	logic [IW-1:0] rd_idx_q;
	logic [7:0]    crc_lo_q;
	logic [15:0]   rx_crc_q;
	logic [7:0]    rd_data_q;
	logic [7:0]    mem [MAX_PAYLOAD];
	logic          out_valid_q;

	// Frame start register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_start_q <= fpcp_pkg::FRAME_START_RST;
		end else if (cfg_we) begin
			frame_start_q <= cfg_wdata;
		end
	end

	// Running CRC over command, length and payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= fpcp_pkg::CRC_INIT;
		end else if (cmd.start) begin
			crc_q <= fpcp_pkg::CRC_INIT;
		end else if (cmd.take_cmd || cmd.take_len || cmd.take_data) begin
			crc_q <= fpcp_pkg::crc_update(crc_q, rx_byte);
		end
	end

	// Frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			fill_q   <= '0;
			rd_idx_q <= '0;
		end else begin
			if (cmd.take_len) begin
				len_q    <= LW'(rx_byte);
				fill_q   <= '0;
				rd_idx_q <= '0;
			end
			if (cmd.take_data) begin
				fill_q <= fill_q + LW'(1);
			end
			if (cmd.out_load) begin
				rd_idx_q <= rd_idx_q + IW'(1);
			end
		end
	end

	// Header and CRC byte holding
	always_ff @(posedge clk) begin
		if (cmd.take_cmd) begin
			cmd_byte_q <= rx_byte;
		end
		if (cmd.take_crc_lo) begin
			crc_lo_q <= rx_byte;
		end
		if (cmd.take_crc_hi) begin
			rx_crc_q <= {rx_byte, crc_lo_q};
		end
	end

	// Payload store, registered read
	always_ff @(posedge clk) begin
		if (cmd.take_data) begin
			mem[fill_q[IW-1:0]] <= rx_byte;
		end
		if (cmd.rd_issue) begin
			rd_data_q <= mem[rd_idx_q];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			command        <= cmd_byte_q;
			payload_length <= 6'(len_q);
			payload_byte   <= (len_q == '0) ? 8'h00 : rd_data_q;
			byte_index     <= 5'(rd_idx_q);
			received_crc   <= rx_crc_q;
			last           <= sts.rd_last;
		end
	end

	assign out_valid = out_valid_q;

	// Status toward the controller
	always_comb begin
		sts.start_hit = (rx_byte == frame_start_q);
		sts.len_big   = (rx_byte > MaxByte);
		sts.len_zero  = (rx_byte == 8'h00);
		sts.data_done = ((fill_q + LW'(1)) == len_q);
		sts.crc_ok    = ({rx_byte, crc_lo_q} == crc_q);
		sts.rd_last   = (len_q == '0) || ((LW'(rd_idx_q) + LW'(1)) == len_q);
		sts.out_free  = !out_valid_q || out_ready;
	end

endmodule

// File: sv/fpcp_ctrl.sv
// Controller state machine of the framed packet parser: frame phases and
// the payload drain sequence. Depends on fpcp_pkg.
module fpcp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  fpcp_pkg::sts_t    sts,
	output fpcp_pkg::cmd_t    cmd
);

	fpcp_pkg::state_t state_q, state_d;
	logic in_fire;

	// Bytes are taken in every receive phase, never during the drain
	assign in_ready = !(state_q == fpcp_pkg::ST_RD || state_q == fpcp_pkg::ST_LOAD);
	assign in_fire  = in_valid && in_ready;

	// Commands
	always_comb begin
		cmd.start       = (state_q == fpcp_pkg::ST_IDLE) && in_fire && sts.start_hit;
		cmd.take_cmd    = (state_q == fpcp_pkg::ST_CMD) && in_fire;
		cmd.take_len    = (state_q == fpcp_pkg::ST_LEN) && in_fire && !sts.len_big;
		cmd.take_data   = (state_q == fpcp_pkg::ST_DATA) && in_fire;
		cmd.take_crc_lo = (state_q == fpcp_pkg::ST_CRC_LO) && in_fire;
		cmd.take_crc_hi = (state_q == fpcp_pkg::ST_CRC_HI) && in_fire;
		cmd.rd_issue    = (state_q == fpcp_pkg::ST_RD);
		cmd.out_load    = (state_q == fpcp_pkg::ST_LOAD) && sts.out_free;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fpcp_pkg::ST_IDLE: begin
				if (in_fire && sts.start_hit) state_d = fpcp_pkg::ST_CMD;
			end
			fpcp_pkg::ST_CMD: begin
				if (in_fire) state_d = fpcp_pkg::ST_LEN;
			end
			fpcp_pkg::ST_LEN: begin
				if (in_fire) begin
					if (sts.len_big) begin
						state_d = fpcp_pkg::ST_IDLE;
					end else if (sts.len_zero) begin
						state_d = fpcp_pkg::ST_CRC_LO;
					end else begin
						state_d = fpcp_pkg::ST_DATA;
					end
				end
			end
			fpcp_pkg::ST_DATA: begin
				if (in_fire && sts.data_done) state_d = fpcp_pkg::ST_CRC_LO;
			end
			fpcp_pkg::ST_CRC_LO: begin
				if (in_fire) state_d = fpcp_pkg::ST_CRC_HI;
			end
			fpcp_pkg::ST_CRC_HI: begin
				if (in_fire) state_d = sts.crc_ok ? fpcp_pkg::ST_RD : fpcp_pkg::ST_IDLE;
			end
			fpcp_pkg::ST_RD: begin
				state_d = fpcp_pkg::ST_LOAD;
			end
			fpcp_pkg::ST_LOAD: begin
				if (sts.out_free) state_d = sts.rd_last ? fpcp_pkg::ST_IDLE : fpcp_pkg::ST_RD;
			end
			default: begin
				state_d = fpcp_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpcp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Output register is only loaded when it can take the beat
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("output load while output register busy");

	// A CRC mismatch drops the frame and returns to the hunt
	a_crc_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take_crc_hi && !sts.crc_ok) |=> (state_q == fpcp_pkg::ST_IDLE))
		else $error("bad frame not dropped");

	// Every store read is followed by a load attempt on the next cycle
	a_rd_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_issue |=> (state_q == fpcp_pkg::ST_LOAD && !in_ready))
		else $error("store read not followed by load");

	// A good frame starts the drain with a store read
	a_crc_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take_crc_hi && sts.crc_ok) |=> cmd.rd_issue)
		else $error("good frame not drained");

endmodule

// File: dv/fpcp_frame_checker.sv
// Frame checker for the framed packet parser: follows the config port and both
// channels, predicts the result beats of each frame and compares them.
// Depends on fpcp_pkg (state names, CRC and register constants).
module fpcp_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  command,
	input  logic [5:0]  payload_length,
	input  logic [7:0]  payload_byte,
	input  logic [4:0]  byte_index,
	input  logic [15:0] received_crc,
	input  logic        last,
	output int          fail_count,
	output int          pending,
	output logic        hunting
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAYLOAD_MAX = fpcp_pkg::MAX_PAYLOAD_DEF;
	localparam int SHOW_LIMIT  = 10;

	typedef struct packed {
		logic [7:0]  command;
		logic [5:0]  payload_length;
		logic [7:0]  payload_byte;
		logic [4:0]  byte_index;
		logic [15:0] received_crc;
		logic        last;
	} result_beat_t;

	// Beats owed by the block, oldest first
	result_beat_t expected_beats[$];

	// Predicted parser state
	fpcp_pkg::state_t parse_st;
	logic [7:0]  start_byte;
	logic [7:0]  frame_cmd;
	logic [5:0]  frame_len;
	logic [5:0]  bytes_stored;
	logic [7:0]  payload_mem [PAYLOAD_MAX];
	logic [15:0] crc_acc;
	logic [7:0]  crc_lo;

	// CRC-16/CCITT-FALSE, one data bit at a time, MSB first
	function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] r;
		r = crc;
		for (int i = 7; i >= 0; i--) begin
			if (r[15] ^ data[i]) begin
				r = {r[14:0], 1'b0} ^ fpcp_pkg::CRC_POLY;
			end else begin
				r = {r[14:0], 1'b0};
			end
		end
		return r;
	endfunction

	// Advance the predicted parser by one received byte; a good CRC queues the frame
	function automatic void advance_parser(input logic [7:0] b);
		result_beat_t beat;
		logic [15:0]  frame_crc;
		unique case (parse_st)
			fpcp_pkg::ST_CMD: begin
				frame_cmd = b;
				crc_acc   = crc16_next(crc_acc, b);
				parse_st  = fpcp_pkg::ST_LEN;
			end
			fpcp_pkg::ST_LEN: begin
				if (b > PAYLOAD_MAX) begin
					// over-length frame: dropped here, the byte starts nothing
					parse_st = fpcp_pkg::ST_IDLE;
				end else begin
					frame_len    = b[5:0];
					bytes_stored = '0;
					crc_acc      = crc16_next(crc_acc, b);
					parse_st     = (b == 8'd0) ? fpcp_pkg::ST_CRC_LO : fpcp_pkg::ST_DATA;
				end
			end
			fpcp_pkg::ST_DATA: begin
				if (bytes_stored < PAYLOAD_MAX) begin
					payload_mem[bytes_stored] = b;
				end
				bytes_stored++;
				crc_acc = crc16_next(crc_acc, b);
				if (bytes_stored >= frame_len) begin
					parse_st = fpcp_pkg::ST_CRC_LO;
				end
			end
			fpcp_pkg::ST_CRC_LO: begin
				crc_lo   = b;
				parse_st = fpcp_pkg::ST_CRC_HI;
			end
			fpcp_pkg::ST_CRC_HI: begin
				frame_crc = {b, crc_lo};
				parse_st  = fpcp_pkg::ST_IDLE;
				if (frame_crc == crc_acc) begin
					beat.command        = frame_cmd;
					beat.payload_length = frame_len;
					beat.received_crc   = frame_crc;
					if (frame_len == 6'd0) begin
						// empty frame: a single beat with zero data
						beat.payload_byte = '0;
						beat.byte_index   = '0;
						beat.last         = 1'b1;
						expected_beats.push_back(beat);
					end else begin
						for (int i = 0; i < frame_len; i++) begin
							beat.payload_byte = payload_mem[i];
							beat.byte_index   = i[4:0];
							beat.last         = (i == frame_len - 1);
							expected_beats.push_back(beat);
						end
					end
				end
			end
			default: begin
				// idle hunt; unknown states fall back here too
				parse_st = fpcp_pkg::ST_IDLE;
				if (b == start_byte) begin
					parse_st     = fpcp_pkg::ST_CMD;
					frame_cmd    = '0;
					frame_len    = '0;
					bytes_stored = '0;
					crc_acc      = fpcp_pkg::CRC_INIT;
				end
			end
		endcase
	endfunction

	// Compare result beats, then feed accepted bytes to the prediction
	always @(posedge clk or negedge arst_n) begin
		result_beat_t seen;
		result_beat_t want;
		if (!arst_n) begin
			expected_beats.delete();
			parse_st     = fpcp_pkg::ST_IDLE;
			start_byte   = fpcp_pkg::FRAME_START_RST;
			frame_cmd    = '0;
			frame_len    = '0;
			bytes_stored = '0;
			crc_acc      = fpcp_pkg::CRC_INIT;
			crc_lo       = '0;
			fail_count   = 0;
		end else begin
			if (cfg_we) begin
				start_byte = cfg_wdata;
			end
			if (out_valid && out_ready) begin
				seen = {command, payload_length, payload_byte, byte_index, received_crc, last};
				if (expected_beats.size() == 0) begin
					fail_count++;
					if (fail_count <= SHOW_LIMIT) begin
						$display("%0t: unexpected beat cmd %02h len %0d byte %02h idx %0d crc %04h last %0b",
							$realtime, seen.command, seen.payload_length, seen.payload_byte,
							seen.byte_index, seen.received_crc, seen.last);
					end
				end else begin
					want = expected_beats.pop_front();
					if (seen !== want) begin
						fail_count++;
						if (fail_count <= SHOW_LIMIT) begin
							$display("%0t: beat mismatch, expected cmd %02h len %0d byte %02h idx %0d crc %04h last %0b",
								$realtime, want.command, want.payload_length, want.payload_byte,
								want.byte_index, want.received_crc, want.last);
							$display("%0t:                    got cmd %02h len %0d byte %02h idx %0d crc %04h last %0b",
								$realtime, seen.command, seen.payload_length, seen.payload_byte,
								seen.byte_index, seen.received_crc, seen.last);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				advance_parser(rx_byte);
			end
		end
		pending = expected_beats.size();
		hunting = (parse_st == fpcp_pkg::ST_IDLE);
	end

endmodule

// File: dv/framed_packet_crc_parser_core_test.sv
// Testbench top for the framed packet parser: clock, reset, frame traffic,
// output back-pressure, watchdog and verdict. Depends on fpcp_pkg,
// framed_packet_crc_parser_core and fpcp_frame_checker.
module framed_packet_crc_parser_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF       = 6;
	localparam int LONG_HOLD      = 200;
	localparam int SETTLE_CYCLES  = 80;
	localparam int WATCHDOG_LIMIT = 4000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [7:0]  cfg_wdata = '0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  command;
	logic [5:0]  payload_length;
	logic [7:0]  payload_byte;
	logic [4:0]  byte_index;
	logic [15:0] received_crc;
	logic        last;

	int          fail_count;
	int          pending;
	logic        hunting;

	bit          gaps_on        = 1'b1;
	bit          long_hold_req  = 1'b0;
	int          bytes_sent     = 0;
	logic [7:0]  start_byte_now = fpcp_pkg::FRAME_START_RST;
	logic [7:0]  frame_payload[$];

	always #(CLK_HALF) clk = ~clk;

	framed_packet_crc_parser_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.command        (command),
		.payload_length (payload_length),
		.payload_byte   (payload_byte),
		.byte_index     (byte_index),
		.received_crc   (received_crc),
		.last           (last)
	);

	fpcp_frame_checker u_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.command        (command),
		.payload_length (payload_length),
		.payload_byte   (payload_byte),
		.byte_index     (byte_index),
		.received_crc   (received_crc),
		.last           (last),
		.fail_count     (fail_count),
		.pending        (pending),
		.hunting        (hunting)
	);

	// Offer one byte from a falling edge, return at the falling edge after its beat
	task automatic send_byte(input logic [7:0] b);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		bytes_sent++;
	endtask

	function automatic void fill_random_payload(input int n);
		frame_payload.delete();
		repeat (n) frame_payload.push_back(8'($urandom_range(0, 255)));
	endfunction

	// Full frame around frame_payload; a spoiled CRC gets one bit flipped
	task automatic send_frame(input logic [7:0] cmd, input bit spoil_crc);
		logic [15:0] crc;
		logic [7:0]  len;
		len = 8'(frame_payload.size());
		crc = fpcp_pkg::crc_update(fpcp_pkg::CRC_INIT, cmd);
		crc = fpcp_pkg::crc_update(crc, len);
		foreach (frame_payload[i]) crc = fpcp_pkg::crc_update(crc, frame_payload[i]);
		if (spoil_crc) begin
			crc ^= 16'h0001 << $urandom_range(0, 15);
		end
		send_byte(start_byte_now);
		send_byte(cmd);
		send_byte(len);
		foreach (frame_payload[i]) send_byte(frame_payload[i]);
		send_byte(crc[7:0]);
		send_byte(crc[15:8]);
	endtask

	// Mostly well-formed frames, some bad CRCs, over-length headers and noise
	task automatic random_traffic(input int upto);
		int         pick;
		int         len;
		logic [7:0] cmd;
		while (bytes_sent < upto) begin
			pick = $urandom_range(0, 19);
			cmd  = 8'($urandom_range(0, 255));
			if (pick < 15) begin
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 32) : $urandom_range(0, 6);
				fill_random_payload(len);
				send_frame(cmd, pick >= 13);
			end else if (pick < 17) begin
				send_byte(start_byte_now);
				send_byte(cmd);
				send_byte(8'($urandom_range(33, 255)));
			end else begin
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
			end
			// optional end-of-frame marker, just ignored by the idle hunt
			if ($urandom_range(0, 3) == 0 && start_byte_now != 8'h5A) begin
				send_byte(8'h5A);
			end
		end
	endtask

	// Bring the parser back to its idle hunt and wait out every pending beat
	task automatic settle();
		logic [7:0] flush;
		flush = (start_byte_now == 8'hFF) ? 8'hFE : 8'hFF;
		while (!hunting) send_byte(flush);
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_start_byte(input logic [7:0] v);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		start_byte_now = v;
	endtask

	// Result side: random stall bursts, plus one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				out_ready <= 1'b1;
			end else if (gaps_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles with no beat on either channel
	initial begin
		int stalled;
		stalled = 0;
		while (stalled < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
				stalled = 0;
			end else begin
				stalled++;
			end
		end
		$display("simulation failed");
		$finish;
	end

	// Stimulus and verdict
	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty frame, all-ones frame, over-length, bad CRC,
		// start byte as command and payload, trailing marker
		frame_payload.delete();
		send_frame(8'h00, 1'b0);
		frame_payload = {8'hFF};
		send_frame(8'hFF, 1'b0);
		send_byte(start_byte_now);
		send_byte(8'h3C);
		send_byte(8'd33);
		frame_payload.delete();
		send_frame(8'h7E, 1'b1);
		frame_payload = {start_byte_now, start_byte_now};
		send_frame(start_byte_now, 1'b0);
		send_byte(8'h5A);

		random_traffic(90);

		// start byte zero; long output hold-off while frames keep coming
		set_start_byte(8'h00);
		long_hold_req = 1'b1;
		fill_random_payload(32);
		send_frame(8'($urandom_range(0, 255)), 1'b0);
		repeat (3) begin
			fill_random_payload($urandom_range(0, 8));
			send_frame(8'($urandom_range(0, 255)), 1'b0);
		end
		random_traffic(150);

		set_start_byte(8'hFF);
		random_traffic(210);

		// final stretch with no idling on either side
		set_start_byte(8'($urandom_range(0, 255)));
		gaps_on = 1'b0;
		random_traffic(280);
		in_valid <= 1'b0;

		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
